/* rtl/dsed_pkg.sv */
// shared types and codes for the dle stx/etx deframer
`default_nettype none

package dsed_pkg;

  // control characters of the stuffed stream
  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_ETX = 8'h03;
  localparam logic [7:0] CODE_DLE = 8'h10;

  // field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 5;
  localparam int OUT_DATA_W = 16;

  // controller states
  typedef enum logic [1:0] {
    ST_RX  = 2'd0,
    ST_RD  = 2'd1,
    ST_OUT = 2'd2
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;      // accept the byte on the input channel
    logic rd_issue;  // read the store at the current read index
    logic rd_next;   // advance the read index
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic close;     // byte on input is dle etx closing an open frame
    logic last;      // current read index is the final byte of the frame, or the frame is empty
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/dle_stx_etx_deframer.sv */
// top level of the dle stx/etx deframer
//
//  channel | dir | payload
//  in_*    | in  | tdata[7:0] rx_byte
//  out_*   | out | tdata[7:0] frame_byte, tdata[12:8] frame_length; tlast is_last
//
// a received byte is taken while no frame is being read out
// a closed frame is read out byte by byte, each byte with a store read and then
// a result request; an empty frame gives one store read and one zero-byte result
// input is held off during readout; out_tready low holds the current result
// synchronous active-low reset clears flags, fill count, read index and controller state
`default_nettype none

module dle_stx_etx_deframer #(
  parameter int MAX_FRAME_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] frame_byte, [12:8] frame_length, rest 0
  output logic             out_tlast   // is_last
);
  import dsed_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [BYTE_W-1:0] frame_byte;
  logic [LEN_W-1:0]  frame_length;

  dsed_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  dsed_dp #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_byte      (in_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .frame_byte   (frame_byte),
    .frame_length (frame_length)
  );

  // pack the result request
  assign out_tdata = {(OUT_DATA_W - BYTE_W - LEN_W)'(0), frame_length, frame_byte};
  assign out_tlast = stat.last;

endmodule

`default_nettype wire

/* rtl/dsed_dp.sv */
// datapath: unstuffing flags, fill count, frame store and readout
`default_nettype none

module dsed_dp #(
  parameter int MAX_FRAME_BYTES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [dsed_pkg::BYTE_W-1:0]     rx_byte,
  input  wire dsed_pkg::dp_cmd_t               cmd,
  output dsed_pkg::dp_stat_t                   stat,
  output logic [dsed_pkg::BYTE_W-1:0]          frame_byte,
  output logic [dsed_pkg::LEN_W-1:0]           frame_length
);
  import dsed_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
  localparam logic [CW-1:0] MAX_FILL = CW'(MAX_FRAME_BYTES);

  logic            in_frame_r, in_frame_nxt;
  logic            esc_r, esc_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [AW-1:0]   rd_idx_r;
  logic [BYTE_W-1:0] rdata_r;
  logic [BYTE_W-1:0] mem [MAX_FRAME_BYTES];
  logic            wr_en;
  logic            is_dle, is_stx, is_etx;

  assign is_dle = (rx_byte == CODE_DLE);
  assign is_stx = (rx_byte == CODE_STX);
  assign is_etx = (rx_byte == CODE_ETX);

  // byte decode and framing flags
  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    fill_nxt     = fill_r;
    wr_en        = 1'b0;
    if (cmd.take) begin
      if (!esc_r && is_dle) begin
        esc_nxt = 1'b1;
      end else if (esc_r && is_stx) begin
        esc_nxt      = 1'b0;
        in_frame_nxt = 1'b1;
        fill_nxt     = '0;
      end else if (esc_r && !is_dle) begin
        // dle etx or a bad escape both end the frame
        esc_nxt      = 1'b0;
        in_frame_nxt = 1'b0;
      end else begin
        // plain byte or literal dle
        esc_nxt = 1'b0;
        if (in_frame_r) begin
          if (fill_r < MAX_FILL) begin
            wr_en    = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end else begin
            in_frame_nxt = 1'b0;
          end
        end
      end
    end
  end

  assign stat.close = esc_r && is_etx && in_frame_r;
  assign stat.last  = (fill_r == '0) || ((CW'(rd_idx_r) + 1'b1) == fill_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      fill_r     <= '0;
      rd_idx_r   <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      fill_r     <= fill_nxt;
      if (cmd.take && stat.close) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_next) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[AW-1:0]] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

  // empty frame reads as a zero byte
  assign frame_byte   = (fill_r == '0) ? '0 : rdata_r;
  assign frame_length = LEN_W'(fill_r);

endmodule

`default_nettype wire

/* rtl/dsed_ctrl.sv */
// controller: receive, store read and result handshake sequencing
`default_nettype none

module dsed_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output dsed_pkg::dp_cmd_t       cmd,
  input  wire dsed_pkg::dp_stat_t stat
);
  import dsed_pkg::*;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RX: begin
        if (in_tvalid && stat.close) state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = stat.last ? ST_RX : ST_RD;
      end
      default: begin
        state_nxt = ST_RX;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    cmd.take     = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.rd_next  = 1'b0;
    case (state_r)
      ST_RX: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
      end
      ST_OUT: begin
        out_tvalid  = 1'b1;
        cmd.rd_next = out_tready && !stat.last;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RX;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire
